// ===== rtl/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// Depends on nothing; every other file refers to it by scoped names.
package fpba_pkg;

  localparam int MaxBlocks = 16;
  localparam int SizeBits  = 16;
  localparam int QueueDepth = 2;

  localparam int BlockIdxW  = 4;
  localparam int AmountW    = 16;
  localparam int FitModeW   = 2;
  localparam int BlockCntW  = 5;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 5;

  localparam int IdxW   = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int CntW   = $clog2(MaxBlocks + 1);
  localparam int QPtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW  = $clog2(QueueDepth + 1);

  localparam logic [AmountW-1:0] AmountMask =
      (SizeBits >= AmountW) ? {AmountW{1'b1}} : AmountW'((64'd1 << SizeBits) - 64'd1);

  typedef enum logic [FitModeW-1:0] {
    FitFirst = 2'd0,
    FitBest  = 2'd1,
    FitWorst = 2'd2
  } fit_mode_e;

  typedef enum logic {
    FuncLoad  = 1'b0,
    FuncAlloc = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFitMode    = 1'b0,
    CfgBlockCount = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } back_state_e;

  typedef struct packed {
    logic                 func;
    logic [BlockIdxW-1:0] block_index;
    logic [AmountW-1:0]   amount;
  } req_t;

  typedef struct packed {
    logic                 granted;
    logic [BlockIdxW-1:0] chosen_block;
    logic [AmountW-1:0]   remaining_size;
  } rsp_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                 is_load;
    logic                 wr_ok;
    logic [BlockIdxW-1:0] idx;
    logic [AmountW-1:0]   amount;
  } cmd_t;

endpackage

// ===== rtl/fpba_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on fpba_pkg.
module fpba_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fpba_pkg::req_t   in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output fpba_pkg::cmd_t   cmd_o
);

  fpba_pkg::cmd_t                    fifo_q [fpba_pkg::QueueDepth];
  logic [fpba_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [fpba_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [fpba_pkg::QCntW-1:0]        cnt_q, cnt_d;
  fpba_pkg::cmd_t                    cls;
  logic                              push, pop;

  always_comb begin
    cls.is_load = (in_data_i.func == fpba_pkg::FuncLoad);
    cls.wr_ok   = (32'(in_data_i.block_index) < fpba_pkg::MaxBlocks);
    cls.idx     = in_data_i.block_index;
    cls.amount  = in_data_i.amount & fpba_pkg::AmountMask;
  end

  assign in_ready_o  = (cnt_q != fpba_pkg::QCntW'(fpba_pkg::QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/fpba_back.sv =====
// Back end: size table, configuration registers, scan engine and result register.
// Depends on fpba_pkg.
module fpba_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  fpba_pkg::cmd_t                cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fpba_pkg::rsp_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [fpba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fpba_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [fpba_pkg::SizeBits-1:0]  mem [fpba_pkg::MaxBlocks];
  logic [fpba_pkg::MaxBlocks-1:0] vld_q;
  logic [fpba_pkg::SizeBits-1:0]  rd_data_q;
  logic                           rd_vld_q;

  logic [fpba_pkg::FitModeW-1:0]  mode_q;
  logic [fpba_pkg::BlockCntW-1:0] bcnt_q;

  fpba_pkg::back_state_e          state_q, state_d;
  logic [fpba_pkg::CntW-1:0]      issue_q, issue_d;
  logic [fpba_pkg::CntW-1:0]      limit_q, limit_d;
  logic [fpba_pkg::AmountW-1:0]   amount_q, amount_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [fpba_pkg::IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic                           found_q, found_d;
  logic [fpba_pkg::IdxW-1:0]      pick_q, pick_d;
  logic [fpba_pkg::SizeBits-1:0]  best_q, best_d;
  logic                           out_vld_q, out_vld_d;
  fpba_pkg::rsp_t                 out_q, out_d;

  logic                           out_free;
  logic                           mem_we;
  logic [fpba_pkg::IdxW-1:0]      mem_waddr;
  logic [fpba_pkg::SizeBits-1:0]  mem_wdata;
  logic [fpba_pkg::IdxW-1:0]      rd_addr;
  logic [fpba_pkg::SizeBits-1:0]  cur;
  logic [fpba_pkg::SizeBits-1:0]  diff;
  logic                           fits, take;

  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign rd_addr     = issue_q[fpba_pkg::IdxW-1:0];
  assign cur         = rd_vld_q ? rd_data_q : '0;
  assign diff        = best_q - fpba_pkg::SizeBits'(amount_q);

  always_comb begin
    fits = (32'(cur) >= 32'(amount_q));
    take = fits && (!found_q
        || (mode_q == fpba_pkg::FitBest  && cur < best_q)
        || (mode_q == fpba_pkg::FitWorst && cur > best_q));
  end

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    limit_d     = limit_q;
    amount_d    = amount_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    pick_d      = pick_q;
    best_d      = best_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = fpba_pkg::IdxW'(cmd_i.idx);
    mem_wdata   = fpba_pkg::SizeBits'(cmd_i.amount);

    case (state_q)
      fpba_pkg::StIdle: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          if (cmd_i.is_load) begin
            mem_we               = cmd_i.wr_ok;
            out_vld_d            = 1'b1;
            out_d.granted        = 1'b0;
            out_d.chosen_block   = cmd_i.idx;
            out_d.remaining_size = cmd_i.amount;
          end else begin
            amount_d = cmd_i.amount;
            issue_d  = '0;
            found_d  = 1'b0;
            if (32'(bcnt_q) > fpba_pkg::MaxBlocks) begin
              limit_d = fpba_pkg::CntW'(fpba_pkg::MaxBlocks);
            end else begin
              limit_d = fpba_pkg::CntW'(bcnt_q);
            end
            state_d = fpba_pkg::StScan;
          end
        end
      end
      fpba_pkg::StScan: begin
        if (issue_q != limit_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[fpba_pkg::IdxW-1:0];
          issue_d   = issue_q + 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = fpba_pkg::StDone;
        end
        if (cmp_vld_q && take) begin
          found_d = 1'b1;
          pick_d  = cmp_idx_q;
          best_d  = cur;
        end
      end
      fpba_pkg::StDone: begin
        if (out_free) begin
          mem_we    = found_q;
          mem_waddr = pick_q;
          mem_wdata = diff;
          out_vld_d = 1'b1;
          if (found_q) begin
            out_d.granted        = 1'b1;
            out_d.chosen_block   = fpba_pkg::BlockIdxW'(pick_q);
            out_d.remaining_size = fpba_pkg::AmountW'(diff);
          end else begin
            out_d = '0;
          end
          state_d = fpba_pkg::StIdle;
        end
      end
      default: begin
        state_d = fpba_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fpba_pkg::StIdle;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      mode_q    <= fpba_pkg::FitFirst;
      bcnt_q    <= fpba_pkg::BlockCntW'(16);
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
      rd_vld_q  <= vld_q[rd_addr];
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          fpba_pkg::CfgFitMode:    mode_q <= cfg_wdata_i[fpba_pkg::FitModeW-1:0];
          fpba_pkg::CfgBlockCount: bcnt_q <= cfg_wdata_i[fpba_pkg::BlockCntW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q   <= issue_d;
    limit_q   <= limit_d;
    amount_q  <= amount_d;
    cmp_idx_q <= cmp_idx_d;
    found_q   <= found_d;
    pick_q    <= pick_d;
    best_q    <= best_d;
    out_q     <= out_d;
  end

  // size table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

endmodule

// ===== rtl/fit_policy_block_allocator.sv =====
// Top level of the fit-policy block allocator: front queue plus back scan engine.
// Depends on fpba_pkg, fpba_front and fpba_back.
//
// Usage:
//   in_*   : valid/ready channel carrying req_t items. func selects a load
//            (write one table entry) or an allocation request.
//   out_*  : valid/ready channel carrying one rsp_t item per input item,
//            in input order.
//   cfg_*  : write-only registers, index 0 fit_mode, index 1 block_count;
//            write only while the block is idle.
// Operation:
//   The back end takes a load and writes its table entry and result together.
//   For a request it takes the item, issues one table read per entry
//   (min(block_count, 16) entries), drains the read pipeline, then updates the
//   table and writes the result. The two-item queue takes more items while the
//   back end is busy.
// Reset clears the table to zero (per-entry valid bits), fit_mode to first
// fit and block_count to 16. If out_ready_i is low the result register holds
// its item, the back end waits for it and the queue fills, then in_ready_o
// drops.
module fit_policy_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fpba_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fpba_pkg::rsp_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [fpba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fpba_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic           cmd_valid;
  logic           cmd_ready;
  fpba_pkg::cmd_t cmd;

  fpba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  fpba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

// ===== rtl/fpba_checker.sv =====
// Port-level checks for the fit-policy block allocator, bound to the top level.
// Depends on fpba_pkg and fit_policy_block_allocator.
module fpba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input fpba_pkg::rsp_t                out_data_o,
  input logic                          cfg_we_i,
  input logic [fpba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [fpba_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [2:0]                     pend_q;
  logic [fpba_pkg::BlockCntW-1:0] bcnt_q;
  logic                           acc_in, acc_out;

  assign acc_in  = in_valid_i && in_ready_o;
  assign acc_out = out_valid_o && out_ready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      bcnt_q <= fpba_pkg::BlockCntW'(16);
    end else begin
      pend_q <= pend_q + 3'(acc_in) - 3'(acc_out);
      if (cfg_we_i && cfg_index_i == fpba_pkg::CfgBlockCount) begin
        bcnt_q <= cfg_wdata_i[fpba_pkg::BlockCntW-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> pend_q != 3'd0)
    else $error("result item without an outstanding input item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pend_q <= 3'd4)
    else $error("more items in flight than the queue and back end can hold");

  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_data_o.granted |-> 32'(out_data_o.chosen_block) < 32'(bcnt_q))
    else $error("granted block outside the considered range");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);
